// ===== design/uint_to_radix_digits_unit_assert.svh =====
// ----------------------------------------------------------------------------
// uint_to_radix_digits_unit assertion macros
// Concurrent check macros shared by the radix converter RTL.
// ----------------------------------------------------------------------------
`ifndef UINT_TO_RADIX_DIGITS_UNIT_ASSERT_SVH
`define UINT_TO_RADIX_DIGITS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define U2R_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define U2R_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define U2R_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define U2R_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== design/u2r_pkg.sv =====
// ----------------------------------------------------------------------------
// u2r_pkg
// Shared constants, register indexes and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package u2r_pkg;

    // Field widths fixed by the interface
    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS = 2'd1;

    // Character and radix constants
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_A        = 7'd65;
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [DIGIT_W-1:0] RADIX_RESET   = 6'd16;
    localparam logic [DIGIT_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX     = 6'd36;

    // Map a digit value 0..35 to '0'..'9', 'A'..'Z'
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {1'b0, d};
        if (d < DECIMAL_LIMIT) begin
            return d_ext + CHAR_ZERO;
        end
        return d_ext - {1'b0, DECIMAL_LIMIT} + CHAR_A;
    endfunction

    // Clamp a written base into 2..36
    function automatic logic [DIGIT_W-1:0] clamp_radix(input logic [DIGIT_W-1:0] r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end
        if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

endpackage

// ===== design/u2r_ifs.sv =====
// ----------------------------------------------------------------------------
// u2r item channels
// Valid/ready channels for the input value and the output characters.
// ----------------------------------------------------------------------------
interface u2r_value_if
    import u2r_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface u2r_char_if
    import u2r_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

// ===== design/u2r_ram.sv =====
// ----------------------------------------------------------------------------
// u2r_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module u2r_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/u2r_div.sv =====
// ----------------------------------------------------------------------------
// u2r_div
// Restoring divider by a small base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module u2r_div
    import u2r_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [DIGIT_W-1:0]    i_divisor,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [DIGIT_W-1:0]    o_remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_BITS - 1);

    logic [VALUE_BITS-1:0] r_work, n_work;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [DIGIT_W-1:0]    r_divisor;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIGIT_W:0]      w_shifted;
    logic [DIGIT_W:0]      w_diff;
    logic                  w_ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_shifted = {r_rem, r_work[VALUE_BITS-1]};
        w_diff    = w_shifted - {1'b0, r_divisor};
        w_ge      = (w_shifted >= {1'b0, r_divisor});
        n_rem     = w_ge ? w_diff[DIGIT_W-1:0] : w_shifted[DIGIT_W-1:0];
        n_work    = {r_work[VALUE_BITS-2:0], w_ge};
    end

    // Load on start, otherwise advance while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_busy <= (r_cnt != LAST_STEP);
            r_done <= (r_cnt == LAST_STEP);
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work;
    assign o_remainder = r_rem;

endmodule

// ===== design/uint_to_radix_digits_unit.sv =====
// ----------------------------------------------------------------------------
// uint_to_radix_digits_unit
// Converts an unsigned value to ASCII digits in base 2..36, MSD first.
// ----------------------------------------------------------------------------
// Usage:
//   i_value_ch takes one unsigned value per item; ready is high only while
//   the unit is idle. o_char_ch returns one ASCII character per item, most
//   significant digit first, with last set on the final character.
//   The user must write registers radix (index 0) and min_digits (index 1) via
//   i_cfg_we/i_cfg_idx/i_cfg_data only while idle, unenforced by the unit.
//   Radix[5:0] is clamped to 2..36; min_digits over MAX_DIGITS is MAX_DIGITS.
// Timing:
//   Each digit costs one pass of the shared bit-serial divider, VALUE_BITS
//   steps long, so a value with D digits needs D passes before the first
//   character. Each character then goes through a digit RAM read, then
//   presentation, which lasts until the sink is ready.
// Reset:
//   Synchronous, active low; the unit returns idle with radix 16 and no
//   minimum width. The digit RAM is not cleared.
// Stall:
//   A character holds on o_char_ch until taken; no new value is accepted
//   until the last character of the current one has gone.
// ----------------------------------------------------------------------------
`include "uint_to_radix_digits_unit_assert.svh"

module uint_to_radix_digits_unit
    import u2r_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    u2r_value_if.sink             i_value_ch,
    u2r_char_if.source            o_char_ch
);

    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_SHOW = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [DIGIT_W-1:0]    r_radix;
    logic [CFG_DATA_W-1:0] r_min_digits;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_total, n_total;
    logic [CNT_W-1:0]      r_pos, n_pos;
    logic                  r_pad, n_pad;

    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_div_start;
    logic [VALUE_BITS-1:0] w_dividend;
    logic                  w_div_done;
    logic [VALUE_BITS-1:0] w_quot;
    logic [DIGIT_W-1:0]    w_rem;
    logic [CNT_W-1:0]      w_count_inc;
    logic                  w_more;
    logic [CNT_W-1:0]      w_min_sat;
    logic                  w_ram_we;
    logic                  w_ram_re;
    logic [DIGIT_W-1:0]    w_ram_rdata;

    assign w_in_acc  = i_value_ch.valid && i_value_ch.ready;
    assign w_out_acc = o_char_ch.valid && o_char_ch.ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix      <= RADIX_RESET;
            r_min_digits <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIX:      r_radix      <= clamp_radix(i_cfg_data[DIGIT_W-1:0]);
                REG_MIN_DIGITS: r_min_digits <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Shared divider
    u2r_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (r_radix),
        .o_done      (w_div_done),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    // Digit store, least significant digit at address zero
    u2r_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_rem),
        .i_re    (w_ram_re),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Sequencer: divide until the quotient is zero or the digit store is full, then read digits back
    always_comb begin
        w_count_inc = r_count + 1'b1;
        w_more      = (w_quot != '0) && (w_count_inc < MAX_CNT);
        w_min_sat   = (r_min_digits > CFG_DATA_W'(MAX_DIGITS)) ? MAX_CNT
                                                               : CNT_W'(r_min_digits);
        w_dividend  = (r_state == S_IDLE) ? i_value_ch.value[VALUE_BITS-1:0] : w_quot;
        w_div_start = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_pos       = r_pos;
        n_pad       = r_pad;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_div_start = 1'b1;
                    n_count     = '0;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_ram_we = 1'b1;
                    n_count  = w_count_inc;
                    if (w_more) begin
                        w_div_start = 1'b1;
                    end else begin
                        n_total = (w_count_inc > w_min_sat) ? w_count_inc : w_min_sat;
                        n_pos   = ((w_count_inc > w_min_sat) ? w_count_inc : w_min_sat)
                                  - 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_pad    = (r_pos >= r_count);
                w_ram_re = (r_pos < r_count);
                n_state  = S_SHOW;
            end
            S_SHOW: begin
                if (w_out_acc) begin
                    if (r_pos == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos - 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Emission bookkeeping
    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_pos   <= n_pos;
        r_pad   <= n_pad;
    end

    // Channel outputs
    assign i_value_ch.ready  = (r_state == S_IDLE);
    assign o_char_ch.valid    = (r_state == S_SHOW);
    assign o_char_ch.out_char = r_pad ? CHAR_ZERO : digit_char(w_ram_rdata);
    assign o_char_ch.last     = (r_pos == '0);

    // Checks
    `U2R_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, i_value_ch.ready, !o_char_ch.valid,
        "input ready while a character is shown")
    `U2R_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, w_out_acc && o_char_ch.last,
        i_value_ch.ready, "unit not idle after the last character")
    `U2R_ASSERT_IMPL(a_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV,
        "divider finished outside the divide phase")
    `U2R_ASSERT_IMPL(a_pos_in_range, i_clk, i_rst_n, r_state == S_SHOW,
        (r_pos < r_total) && (r_count != '0), "character position out of range")

endmodule

// ===== bench/u2r_digit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// u2r_digit_checker
// Watches the value and character channels and the register port of the
// radix converter. Works out the character string of every accepted value in
// the current base and minimum width. Compares each character taken from the
// unit, code and last mark, against the oldest one outstanding.
// ----------------------------------------------------------------------------
module u2r_digit_checker
    import u2r_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    u2r_value_if                  i_value_ch,
    u2r_char_if                   i_char_ch,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int DIGITS_MAX = 64;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_item;

    t_char_item         char_queue[$];
    t_char_item         head;
    logic [DIGIT_W-1:0] base_reg = RADIX_RESET;
    logic [6:0]         width_reg = '0;
    int                 error_count = 0;
    int                 pending_q = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_q;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Split a value into digits, pad to the minimum width, queue the characters
    function automatic void predict_chars(input logic [VALUE_W-1:0] v);
        logic [DIGIT_W-1:0] digits[DIGITS_MAX];
        logic [VALUE_W-1:0] q;
        logic [DIGIT_W-1:0] d;
        int                 count;
        int                 width;
        int                 total;
        int                 pos;
        t_char_item         item;
        q     = v;
        count = 0;
        do begin
            digits[count] = DIGIT_W'(q % base_reg);
            count++;
            q = q / base_reg;
        end while (q != 0 && count < DIGITS_MAX);
        width = (width_reg > DIGITS_MAX) ? DIGITS_MAX : int'(width_reg);
        total = (count > width) ? count : width;
        for (int k = 0; k < total; k++) begin
            pos = total - 1 - k;
            if (pos >= count) begin
                item.code = CHAR_ZERO;
            end else begin
                d = digits[pos];
                if (d < DECIMAL_LIMIT) begin
                    item.code = CHAR_ZERO + CHAR_W'(d);
                end else begin
                    item.code = CHAR_A + CHAR_W'(d - DECIMAL_LIMIT);
                end
            end
            item.last = (k == total - 1);
            char_queue.push_back(item);
        end
    endfunction

    // Track registers, predict on each value item, compare each character item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_queue.delete();
            base_reg  = RADIX_RESET;
            width_reg = '0;
            pending_q <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RADIX: begin
                        base_reg = i_cfg_data[DIGIT_W-1:0];
                        if (base_reg < RADIX_MIN) begin
                            base_reg = RADIX_MIN;
                        end else if (base_reg > RADIX_MAX) begin
                            base_reg = RADIX_MAX;
                        end
                    end
                    REG_MIN_DIGITS: begin
                        width_reg = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_value_ch.valid && i_value_ch.ready) begin
                predict_chars(i_value_ch.value);
            end
            if (i_char_ch.valid && i_char_ch.ready) begin
                if (char_queue.size() == 0) begin
                    report_mismatch($sformatf("char 0x%02h last %0b with nothing outstanding",
                                              i_char_ch.out_char, i_char_ch.last));
                end else begin
                    head = char_queue.pop_front();
                    if (i_char_ch.out_char !== head.code) begin
                        report_mismatch($sformatf("out_char 0x%02h, wanted 0x%02h",
                                                  i_char_ch.out_char, head.code));
                    end
                    if (i_char_ch.last !== head.last) begin
                        report_mismatch($sformatf("last %0b, wanted %0b (char 0x%02h)",
                                                  i_char_ch.last, head.last, head.code));
                    end
                end
            end
            pending_q <= char_queue.size();
        end
    end

endmodule

// ===== bench/uint_to_radix_digits_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uint_to_radix_digits_unit_tb
// Drives values into the radix converter under a series of base and minimum
// width settings: a directed run over zero, one, all ones, powers of the base,
// clamped base writes, oversized minimum widths and writes to spare register
// indexes, then random phases with and without idling on either side. The
// checker beside the unit predicts and compares every character.
// ----------------------------------------------------------------------------
module uint_to_radix_digits_unit_tb;
    import u2r_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int TAIL_CYCLES  = 4300;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 20;

    // Indexes past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    phase_base = 16;
    int                    cycle_count = 0;

    u2r_value_if value_ch ();
    u2r_char_if  char_ch ();

    uint_to_radix_digits_unit uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_value_ch (value_ch),
        .o_char_ch  (char_ch)
    );

    u2r_digit_checker checker_i (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_value_ch (value_ch),
        .i_char_ch  (char_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stall the character sink at random
    always @(posedge clk) begin
        char_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Give up on a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one item, idling first at random; valid stays high afterwards
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < idle_pct) begin
            value_ch.valid <= 1'b0;
            @(posedge clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        @(posedge clk);
        while (!value_ch.ready) begin
            @(posedge clk);
        end
    endtask

    // Drop valid and hold until every character is out and the unit is ready
    task automatic wait_idle();
        value_ch.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending != 0 || !value_ch.ready);
    endtask

    // One register write; the enable stays high until close_writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic close_writes();
        cfg_we <= 1'b0;
    endtask

    // Set base and minimum width once idle, optionally poking the spare indexes
    task automatic set_config(input logic [CFG_DATA_W-1:0] radix_raw,
                              input logic [CFG_DATA_W-1:0] width_raw,
                              input bit                    with_spare);
        wait_idle();
        write_reg(REG_RADIX, radix_raw);
        write_reg(REG_MIN_DIGITS, width_raw);
        if (with_spare) begin
            write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
            write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
        end
        close_writes();
        phase_base = int'(radix_raw[DIGIT_W-1:0]);
        if (phase_base < 2) begin
            phase_base = 2;
        end else if (phase_base > 36) begin
            phase_base = 36;
        end
    endtask

    // Either a power of the base, or one less, or a value of random bit length
    function automatic logic [VALUE_W-1:0] random_value(input int base);
        logic [VALUE_W-1:0] full;
        logic [VALUE_W-1:0] p;
        int                 nbits;
        int                 k;
        full = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, 64);
            p = 64'd1;
            while (k > 0 && p <= 64'hFFFF_FFFF_FFFF_FFFF / 64'(base)) begin
                p = p * 64'(base);
                k--;
            end
            return p - 64'($urandom_range(0, 1));
        end
        nbits = $urandom_range(0, 64);
        if (nbits == 0) begin
            return '0;
        end
        return full >> (64 - nbits);
    endfunction

    initial begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= REG_RADIX;
        cfg_data       <= '0;
        value_ch.valid <= 1'b0;
        value_ch.value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, hexadecimal without padding
        wait_idle();
        send_value(64'd0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'd1);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h0123_4567_89AB_CDEF);

        // Base written above range clamps to 36
        set_config(7'd37, 7'd0, 1'b0);
        send_value(64'd35);
        send_value(64'd36);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);

        // Base written as zero clamps to 2; then a minimum above the limit
        set_config(7'd0, 7'd0, 1'b0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'd0);
        set_config(7'd1, 7'd127, 1'b0);
        send_value(64'd5);
        set_config(7'd1, 7'd64, 1'b0);
        send_value(64'd0);

        // Decimal, with writes to the spare indexes that must change nothing
        set_config(7'd10, 7'd0, 1'b1);
        send_value(64'd9);
        send_value(64'd10);
        send_value(64'd255);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);

        // Upper bit of the data field is dropped: 127 gives 63, clamped to 36
        set_config(7'd127, 7'd3, 1'b0);
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd1296);
        send_value(64'd35);

        // 66 keeps only its low bits, so base 2
        set_config(7'd66, 7'd1, 1'b0);
        send_value(64'd3);

        // Octal, minimum width exactly the full digit count
        set_config(7'd8, 7'd22, 1'b0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'd7);

        // Random phases, cycling through the idling patterns
        for (int ph = 0; ph < PHASES; ph++) begin
            set_config(($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 127))
                                                   : CFG_DATA_W'($urandom_range(2, 36)),
                       ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 127))
                                                   : CFG_DATA_W'($urandom_range(0, 6)),
                       ($urandom_range(0, 2) == 0));
            case (ph % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 67;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 67;
                end
                default: begin
                    idle_pct  = 33;
                    stall_pct = 33;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                send_value(random_value(phase_base));
            end
        end

        // Drain, then allow one full conversion for anything stray
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
